// ===== rtl/icv_pkg.sv =====
// Shared types, constants and helpers for the 3x3 window convolution block.
// No dependencies; used by every module of the block.
package icv_pkg;

    localparam int PIX_W      = 8;
    localparam int CH_N       = 3;
    localparam int PIXV_W     = PIX_W * CH_N;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = PIX_W + 1 + COEF_W;
    localparam int CSUM_W     = PROD_W + 4;
    localparam int RES_W      = 30;
    localparam int CRD_W      = 10;
    localparam int GEO_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIM_W      = 11;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_COEF_TOP = 3'd2,
        CFG_COEF_MID = 3'd3,
        CFG_COEF_BOT = 3'd4,
        CFG_PRESERVE = 3'd5,
        CFG_CHANNELS = 3'd6
    } t_cfg_idx;

    typedef logic [PIXV_W-1:0] t_pix;
    // Window indexed [column][row], row 0 is the oldest row
    typedef t_pix [2:0][2:0] t_win;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] coef_top;
        logic [CFG_DATA_W-1:0] coef_mid;
        logic [CFG_DATA_W-1:0] coef_bot;
        logic                  preserve;
        logic [1:0]            channels;
    } t_kcfg;

    // One classified pixel: its window and the set of results it causes
    typedef struct packed {
        t_win             win;
        logic [3:0]       mask;
        logic [GEO_W-1:0] col;
        logic [GEO_W-1:0] row;
    } t_qent;

    // Clamped index used on the right or bottom edge
    function automatic logic [1:0] edge_sel(input logic [1:0] j);
        return (j == 2'd0) ? 2'd1 : 2'd2;
    endfunction

endpackage

// ===== rtl/image_window_convolution_3x3.sv =====
// Top level of the 3x3 window convolution block: configuration registers and wiring.
// Depends on icv_pkg, icv_front, icv_queue and icv_back.
//
// Usage:
//   Input channel: one raster-order pixel (three 8-bit samples) per beat on
//   i_in_valid / o_in_ready. Output channel: one result per beat on
//   o_out_valid / i_out_ready, in the order of the input pixels that cause them.
//   Configuration: i_cfg_valid / o_cfg_ready write i_cfg_data to register
//   i_cfg_index; the port is always ready. Write only while the block is idle.
// Throughput: one pixel per cycle while the queue has room. A pixel on the right
//   or bottom edge of the frame causes up to four results, issued one per cycle by
//   the back end while the output is not stalled, so edge pixels can back up the queue.
// Pipeline: the front-end stage register, the queue, then the select, multiply, sum
//   and output register stages up to o_out_valid.
// Reset: clears counters, window, queue and pipeline and loads the default
//   configuration (1024x1024, centre tap 256 only, three separate channels).
//   The line buffers are not cleared; stale entries are never used.
// Stall: a stalled receiver holds the output register; the back end stops,
//   the four-entry queue fills and then o_in_ready drops.
module image_window_convolution_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [icv_pkg::PIX_W-1:0]           i_chan0,
    input  logic [icv_pkg::PIX_W-1:0]           i_chan1,
    input  logic [icv_pkg::PIX_W-1:0]           i_chan2,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [icv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [icv_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [icv_pkg::CRD_W-1:0]           o_out_col,
    output logic [icv_pkg::CRD_W-1:0]           o_out_row,
    output logic signed [icv_pkg::RES_W-1:0]    o_res0,
    output logic signed [icv_pkg::RES_W-1:0]    o_res1,
    output logic signed [icv_pkg::RES_W-1:0]    o_res2,
    output logic                                o_last_of_run,
    output logic                                o_frame_done
);
    localparam int DW = icv_pkg::DIM_W;
    localparam int CD = icv_pkg::CFG_DATA_W;

    logic [DW-1:0]   r_width, r_height;
    icv_pkg::t_kcfg  r_kcfg;
    logic            q_push, q_full, q_pop, q_valid;
    icv_pkg::t_qent  q_in, q_out;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width         <= DW'(1024);
            r_height        <= DW'(1024);
            r_kcfg.coef_top <= '0;
            r_kcfg.coef_mid <= CD'(48'h0000_0100_0000);
            r_kcfg.coef_bot <= '0;
            r_kcfg.preserve <= 1'b1;
            r_kcfg.channels <= 2'd3;
        end else if (i_cfg_valid) begin
            case (icv_pkg::t_cfg_idx'(i_cfg_index))
                icv_pkg::CFG_WIDTH:    r_width         <= i_cfg_data[DW-1:0];
                icv_pkg::CFG_HEIGHT:   r_height        <= i_cfg_data[DW-1:0];
                icv_pkg::CFG_COEF_TOP: r_kcfg.coef_top <= i_cfg_data;
                icv_pkg::CFG_COEF_MID: r_kcfg.coef_mid <= i_cfg_data;
                icv_pkg::CFG_COEF_BOT: r_kcfg.coef_bot <= i_cfg_data;
                icv_pkg::CFG_PRESERVE: r_kcfg.preserve <= i_cfg_data[0];
                icv_pkg::CFG_CHANNELS: r_kcfg.channels <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    icv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_chan0      (i_chan0),
        .i_chan1      (i_chan1),
        .i_chan2      (i_chan2),
        .i_cfg_width  (r_width),
        .i_cfg_height (r_height),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_in)
    );

    icv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    icv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_kcfg    (r_kcfg),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_col     (o_out_col),
        .o_row     (o_out_row),
        .o_res0    (o_res0),
        .o_res1    (o_res1),
        .o_res2    (o_res2),
        .o_last    (o_last_of_run),
        .o_done    (o_frame_done)
    );

endmodule

// ===== rtl/icv_front.sv =====
// Front end: accepts pixels, keeps raster counters, line buffers and the window.
// Depends on icv_pkg. Pushes classified pixels toward the back end queue.
module icv_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [icv_pkg::PIX_W-1:0]     i_chan0,
    input  logic [icv_pkg::PIX_W-1:0]     i_chan1,
    input  logic [icv_pkg::PIX_W-1:0]     i_chan2,
    input  logic [icv_pkg::DIM_W-1:0]     i_cfg_width,
    input  logic [icv_pkg::DIM_W-1:0]     i_cfg_height,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output icv_pkg::t_qent                o_q_data
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int GW = icv_pkg::GEO_W;
    localparam int PW = icv_pkg::PIXV_W;

    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [GW-1:0]   w_last, h_last;
    logic            last_col, last_row, acc;

    logic            r_s1_v;
    logic [PW-1:0]   r_s1_pix;
    logic [2*PW-1:0] r_s1_rd;
    logic [CW-1:0]   r_s1_col;
    logic [RW-1:0]   r_s1_row;
    logic [3:0]      r_s1_mask;
    logic            s1_adv;

    logic [2*PW-1:0] r_mem [MAX_WIDTH];
    icv_pkg::t_win   r_win;
    icv_pkg::t_pix   pa, pb, col_top, col_mid;
    logic [2*PW-1:0] wdata;

    // Clamp geometry to the supported range
    always_comb begin
        if (i_cfg_width == '0) begin
            w_last = '0;
        end else if (int'(i_cfg_width) > MAX_WIDTH) begin
            w_last = GW'(MAX_WIDTH - 1);
        end else begin
            w_last = GW'(i_cfg_width) - GW'(1);
        end
        if (i_cfg_height == '0) begin
            h_last = '0;
        end else if (int'(i_cfg_height) > MAX_HEIGHT) begin
            h_last = GW'(MAX_HEIGHT - 1);
        end else begin
            h_last = GW'(i_cfg_height) - GW'(1);
        end
    end

    assign last_col = GW'(r_col) >= w_last;
    assign last_row = GW'(r_row) >= h_last;
    assign s1_adv   = r_s1_v && !i_q_full;
    assign o_ready  = !r_s1_v || s1_adv;
    assign acc      = i_valid && o_ready;

    // Advance raster counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    // Capture the beat and classify it
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix     <= {i_chan2, i_chan1, i_chan0};
            r_s1_col     <= r_col;
            r_s1_row     <= r_row;
            r_s1_mask[0] <= (r_row != '0) && (r_col != '0);
            r_s1_mask[1] <= (r_row != '0) && last_col;
            r_s1_mask[2] <= last_row && (r_col != '0);
            r_s1_mask[3] <= last_row && last_col;
        end
    end

    assign pa    = r_s1_rd[PW-1:0];
    assign pb    = r_s1_rd[2*PW-1:PW];
    assign wdata = {pa, r_s1_pix};

    // Line buffer: read on accept, write back when the pixel moves on; bypass same column
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_col] <= wdata;
        end
        if (acc) begin
            if (s1_adv && (r_s1_col == r_col)) begin
                r_s1_rd <= wdata;
            end else begin
                r_s1_rd <= r_mem[r_col];
            end
        end
    end

    // Build the new column with top clamping
    always_comb begin
        if (r_s1_row == '0) begin
            col_top = r_s1_pix;
            col_mid = r_s1_pix;
        end else if (r_s1_row == RW'(1)) begin
            col_top = pa;
            col_mid = pa;
        end else begin
            col_top = pb;
            col_mid = pa;
        end
    end

    // Shift the window, or fill it at the start of a row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_adv) begin
            if (r_s1_col == '0) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[j] <= {r_s1_pix, col_mid, col_top};
                end
            end else begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= {r_s1_pix, col_mid, col_top};
            end
        end
    end

    // Hand over pixels that cause results
    always_comb begin
        o_q_push      = s1_adv && (r_s1_mask != 4'd0);
        o_q_data.win  = r_win;
        o_q_data.mask = r_s1_mask;
        o_q_data.col  = GW'(r_s1_col);
        o_q_data.row  = GW'(r_s1_row);
        if (r_s1_col == '0) begin
            for (int j = 0; j < 3; j++) begin
                o_q_data.win[j] = {r_s1_pix, col_mid, col_top};
            end
        end else begin
            o_q_data.win[0] = r_win[1];
            o_q_data.win[1] = r_win[2];
            o_q_data.win[2] = {r_s1_pix, col_mid, col_top};
        end
    end

endmodule

// ===== rtl/icv_queue.sv =====
// Short queue between the front end and the back end.
// Depends on icv_pkg for the entry type and depth.
module icv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  icv_pkg::t_qent i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output icv_pkg::t_qent o_data
);
    localparam int PW = icv_pkg::QPTR_W;

    icv_pkg::t_qent r_ent [icv_pkg::QDEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;

    assign o_full  = r_cnt == (PW+1)'(icv_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_ent[r_rp];

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/icv_back.sv =====
// Back end: expands each queued pixel into its results and runs the MAC pipeline.
// Depends on icv_pkg. Stages: select, multiply, sum, output register.
module icv_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  icv_pkg::t_qent                    i_q_data,
    output logic                              o_q_pop,
    input  icv_pkg::t_kcfg                    i_kcfg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [icv_pkg::CRD_W-1:0]         o_col,
    output logic [icv_pkg::CRD_W-1:0]         o_row,
    output logic signed [icv_pkg::RES_W-1:0]  o_res0,
    output logic signed [icv_pkg::RES_W-1:0]  o_res1,
    output logic signed [icv_pkg::RES_W-1:0]  o_res2,
    output logic                              o_last,
    output logic                              o_done
);
    localparam int PXW = icv_pkg::PIX_W;
    localparam int CRW = icv_pkg::CRD_W;
    localparam int PRW = icv_pkg::PROD_W;
    localparam int SMW = icv_pkg::CSUM_W;
    localparam int RSW = icv_pkg::RES_W;
    localparam int CFW = icv_pkg::COEF_W;

    logic          en;
    logic [3:0]    r_taken, pend, pick;
    logic          issue, is_last, use_edge, use_lower;

    logic          r_a_v;
    icv_pkg::t_win r_a_win;   // [row][col] after edge selection
    logic [CRW-1:0] r_a_col, r_a_row;
    logic          r_a_last, r_a_done;

    logic          r_b_v;
    logic signed [PRW-1:0] r_b_prod [3][3][3];
    logic [CRW-1:0] r_b_col, r_b_row;
    logic          r_b_last, r_b_done;

    logic          r_c_v;
    logic signed [SMW-1:0] r_c_sum [3];
    logic [CRW-1:0] r_c_col, r_c_row;
    logic          r_c_last, r_c_done;

    logic signed [CFW-1:0] coef [3][3];
    logic signed [SMW-1:0] acc9 [3];
    logic signed [RSW-1:0] chs [3];
    logic [1:0]            used;

    assign en = !o_valid || i_ready;

    // Pick the next pending result of the head entry
    always_comb begin
        pend      = i_q_data.mask & ~r_taken;
        pick      = pend & (~pend + 4'd1);
        is_last   = (pend & ~pick) == 4'd0;
        issue     = en && i_q_valid;
        o_q_pop   = issue && is_last;
        use_edge  = pick[1] || pick[3];
        use_lower = pick[2] || pick[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else if (issue) begin
            r_taken <= is_last ? 4'd0 : (r_taken | pick);
        end
    end

    // Valid flags of the pipeline stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_a_v   <= i_q_valid;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            o_valid <= r_c_v;
        end
    end

    // Select the clamped 3x3 window and the centre coordinates
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_a_win[i][j] <= i_q_data.win
                        [use_edge  ? icv_pkg::edge_sel(2'(j)) : 2'(j)]
                        [use_lower ? icv_pkg::edge_sel(2'(i)) : 2'(i)];
                end
            end
            r_a_col  <= CRW'(use_edge  ? i_q_data.col : i_q_data.col - 1'b1);
            r_a_row  <= CRW'(use_lower ? i_q_data.row : i_q_data.row - 1'b1);
            r_a_last <= is_last;
            r_a_done <= pick[3];
        end
    end

    // Unpack the kernel
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            coef[0][j] = i_kcfg.coef_top[CFW*j +: CFW];
            coef[1][j] = i_kcfg.coef_mid[CFW*j +: CFW];
            coef[2][j] = i_kcfg.coef_bot[CFW*j +: CFW];
        end
    end

    // Multiply every tap of every channel
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_b_prod[ch][i][j] <= PRW'($signed({1'b0,
                            r_a_win[i][j][PXW*ch +: PXW]}) * coef[i][j]);
                    end
                end
            end
            r_b_col  <= r_a_col;
            r_b_row  <= r_a_row;
            r_b_last <= r_a_last;
            r_b_done <= r_a_done;
        end
    end

    // Add the nine products per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc9[ch] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    acc9[ch] = acc9[ch] + SMW'(r_b_prod[ch][i][j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_c_sum[ch] <= acc9[ch];
            end
            r_c_col  <= r_b_col;
            r_c_row  <= r_b_row;
            r_c_last <= r_b_last;
            r_c_done <= r_b_done;
        end
    end

    // Drop unused channels and merge when not preserving
    always_comb begin
        used = (i_kcfg.channels == 2'd0) ? 2'd1 : i_kcfg.channels;
        for (int ch = 0; ch < 3; ch++) begin
            chs[ch] = (2'(ch) < used) ? RSW'(r_c_sum[ch]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_kcfg.preserve) begin
                o_res0 <= chs[0];
                o_res1 <= chs[1];
                o_res2 <= chs[2];
            end else begin
                o_res0 <= chs[0] + chs[1] + chs[2];
                o_res1 <= '0;
                o_res2 <= '0;
            end
            o_col  <= r_c_col;
            o_row  <= r_c_row;
            o_last <= r_c_last;
            o_done <= r_c_done;
        end
    end

endmodule

// ===== rtl/icv_checker.sv =====
// Port-level checks for the 3x3 window convolution block, bound to the top level.
// Depends only on the top level's ports.
module icv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [9:0]  o_out_col,
    input logic [9:0]  o_out_row,
    input logic        o_last_of_run,
    input logic        o_frame_done
);
    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_col)
            && $stable(o_out_row))
        else $error("stalled result beat changed");

    // Frame end always closes a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_last_of_run)
        else $error("frame_done without last_of_run");

    // Drop results after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind image_window_convolution_3x3 icv_checker u_icv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_col     (o_out_col),
    .o_out_row     (o_out_row),
    .o_last_of_run (o_last_of_run),
    .o_frame_done  (o_frame_done)
);
